>>> hw/rtl/button_press_duration_debounce_macros.svh
// Assertion macros for the button press duration debouncer.
`ifndef BUTTON_PRESS_DURATION_DEBOUNCE_MACROS_SVH
`define BUTTON_PRESS_DURATION_DEBOUNCE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BPDD_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpdd check failed");

// Next-cycle implication, disabled while in reset.
`define BPDD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpdd check failed");

`endif

>>> hw/rtl/bpdd_pkg.sv
// Shared types and constants of the button press duration debouncer.
package bpdd_pkg;

  localparam int unsigned PIN_MAX = 16;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [31:0] DEBOUNCE_RESET = 32'd50000;

  typedef enum logic {
    ACT_EDGE = 1'b0,
    ACT_ACK  = 1'b1
  } action_e;

  typedef enum logic {
    KIND_RELEASE = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic {
    REG_ENABLED_MASK = 1'b0,
    REG_DEBOUNCE_US  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        we;
    reg_idx_e    index;
    logic [31:0] data;
  } cfg_req_t;

  // One classified request, handed from front to back.
  typedef struct packed {
    logic [PIN_MAX-1:0]        release_mask;
    logic [PIN_MAX-1:0][31:0]  held;
    logic [PIN_MAX-1:0]        rising;
    logic [PIN_MAX-1:0]        acked;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/bpdd_front.sv
// Front end: pin state, configuration registers and per-pin classification.
module bpdd_front #(
  parameter int unsigned LANES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpdd_pkg::cfg_req_t   cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_action_i,
  input  logic [15:0]          in_pin_mask_i,
  input  logic [31:0]          in_now_us_i,
  input  logic [3:0]           in_ack_pin_i,
  input  bpdd_pkg::q_status_t  q_status_i,
  output logic                 push_o,
  output bpdd_pkg::entry_t     entry_o
);
  import bpdd_pkg::*;

  logic [LANES-1:0]       enabled_q, enabled_d;
  logic [31:0]            debounce_q, debounce_d;
  logic [LANES-1:0][31:0] stamp_q, stamp_d;
  logic [LANES-1:0]       rising_q, rising_d;

  logic [LANES-1:0][31:0] sum;
  logic [LANES-1:0][31:0] held;
  logic [LANES-1:0]       idle, late, fire, released;
  logic                   accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept;

  // Per-pin classification, all lanes side by side.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i]  = stamp_q[i] + debounce_q;
      held[i] = in_now_us_i - stamp_q[i];
      idle[i] = (stamp_q[i] == 32'd0);
      late[i] = (sum[i] < in_now_us_i);
      fire[i] = in_pin_mask_i[i] && enabled_q[i] && (in_action_i == ACT_EDGE);
    end
  end

  always_comb begin
    stamp_d    = stamp_q;
    rising_d   = rising_q;
    enabled_d  = enabled_q;
    debounce_d = debounce_q;
    released   = '0;
    if (accept) begin
      for (int i = 0; i < LANES; i++) begin
        if (in_action_i == ACT_ACK) begin
          if (in_ack_pin_i == 4'(i)) begin
            stamp_d[i] = 32'd0;
          end
        end else if (fire[i]) begin
          priority if (idle[i]) begin
            stamp_d[i]  = in_now_us_i;
            rising_d[i] = 1'b1;
          end else if (late[i]) begin
            stamp_d[i]    = held[i];
            rising_d[i]   = 1'b0;
            released[i]   = 1'b1;
          end else begin
            rising_d[i] = 1'b1;
          end
        end
      end
    end
    if (cfg_i.we) begin
      unique case (cfg_i.index)
        REG_ENABLED_MASK: begin
          enabled_d = cfg_i.data[LANES-1:0];
          // newly mapped pin starts clean
          for (int i = 0; i < LANES; i++) begin
            if (cfg_i.data[i] && !enabled_q[i]) begin
              stamp_d[i]  = 32'd0;
              rising_d[i] = 1'b0;
            end
          end
        end
        REG_DEBOUNCE_US: begin
          debounce_d = cfg_i.data;
        end
      endcase
    end
  end

  always_comb begin
    entry_o = '0;
    for (int i = 0; i < LANES; i++) begin
      entry_o.release_mask[i] = released[i];
      entry_o.held[i]         = held[i];
      entry_o.rising[i]       = rising_d[i];
    end
    entry_o.acked = (in_action_i == ACT_EDGE) ? in_pin_mask_i : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= '0;
      debounce_q <= DEBOUNCE_RESET;
      stamp_q    <= '0;
      rising_q   <= '0;
    end else begin
      enabled_q  <= enabled_d;
      debounce_q <= debounce_d;
      stamp_q    <= stamp_d;
      rising_q   <= rising_d;
    end
  end

endmodule

>>> hw/rtl/bpdd_queue.sv
// Short request queue between the front and back ends.
module bpdd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bpdd_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output bpdd_pkg::entry_t     entry_o,
  output bpdd_pkg::q_status_t  status_o
);
  import bpdd_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  entry_t          mem_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(QDEPTH));
  assign status_o.empty = (count_q == '0);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/bpdd_back.sv
// Back end: walks the release mask of the head request and drives the results.
module bpdd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpdd_pkg::q_status_t  q_status_i,
  input  bpdd_pkg::entry_t     entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 out_kind_o,
  output logic [3:0]           out_pin_o,
  output logic [31:0]          out_held_us_o,
  output logic [15:0]          out_rising_edge_mask_o,
  output logic [15:0]          out_acked_mask_o,
  output logic                 out_last_o
);
  import bpdd_pkg::*;

  logic               active_q, active_d;
  logic [PIN_MAX-1:0] pend_q, pend_d;
  logic [PIN_MAX-1:0] pend_cur, lowest;
  logic [3:0]         sel_pin;
  logic [31:0]        sel_held;
  logic               advance, issue, is_report;

  logic               out_valid_q, out_valid_d;
  kind_e              kind_q;
  logic [3:0]         pin_q;
  logic [31:0]        held_q;
  logic [15:0]        rising_q, acked_q;
  logic               last_q;

  assign advance   = !out_valid_q || !out_stall_i;
  assign issue     = advance && !q_status_i.empty;
  assign pend_cur  = active_q ? pend_q : entry_i.release_mask;
  assign lowest    = pend_cur & (~pend_cur + 16'd1);
  assign is_report = (pend_cur != '0);
  assign pop_o     = issue && !is_report;

  // one-hot select of the lowest pending pin
  always_comb begin
    sel_pin  = '0;
    sel_held = '0;
    for (int i = 0; i < PIN_MAX; i++) begin
      if (lowest[i]) begin
        sel_pin  = sel_pin | 4'(i);
        sel_held = sel_held | entry_i.held[i];
      end
    end
  end

  always_comb begin
    active_d    = active_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = !q_status_i.empty;
    end
    if (issue) begin
      active_d = is_report;
      pend_d   = pend_cur & ~lowest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_q   <= is_report ? KIND_RELEASE : KIND_SUMMARY;
      pin_q    <= is_report ? sel_pin : 4'd0;
      held_q   <= is_report ? sel_held : 32'd0;
      rising_q <= entry_i.rising;
      acked_q  <= entry_i.acked;
      last_q   <= !is_report;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_kind_o             = kind_q;
  assign out_pin_o              = pin_q;
  assign out_held_us_o          = held_q;
  assign out_rising_edge_mask_o = rising_q;
  assign out_acked_mask_o       = acked_q;
  assign out_last_o             = last_q;

endmodule

>>> hw/rtl/button_press_duration_debounce.sv
// Top level of the button press duration debouncer.
// Tracks press time stamps for up to sixteen buttons. A request is either an
// edge event (pin mask plus the current microsecond time) or an acknowledge
// of one pin. The front end classifies all pins of an edge event side by side
// and updates the stamps and armed edges; an edge event with R releases then
// yields R release reports in ascending pin order and a closing summary, an
// acknowledge yields the summary alone. The output port delivers one result
// per cycle unless the receiver stalls, so a request holds the back end for
// R+1 results (1 to 17); that result loop is what sets the sustained rate.
// The front end takes a new request every cycle while the two-entry queue
// between the ends has room, so it keeps accepting while results are still
// draining. Control state and stamps reset directly; queue storage and
// result data have no reset, and no clearing pass is needed after reset.
// Configuration: index 0 enabled_mask, index 1 debounce_us; ready is
// always high, and writes are expected only while no request is in flight.
`include "button_press_duration_debounce_macros.svh"

module button_press_duration_debounce #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_action_i,
  input  logic [15:0] in_pin_mask_i,
  input  logic [31:0] in_now_us_i,
  input  logic [3:0]  in_ack_pin_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [3:0]  out_pin_o,
  output logic [31:0] out_held_us_o,
  output logic [15:0] out_rising_edge_mask_o,
  output logic [15:0] out_acked_mask_o,
  output logic        out_last_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bpdd_pkg::*;

  // Pins beyond the 16-bit mask can never be addressed.
  localparam int unsigned LANES = (PIN_COUNT < PIN_MAX) ? PIN_COUNT : PIN_MAX;

  cfg_req_t   cfg_req;
  q_status_t  q_status;
  entry_t     push_entry, head_entry;
  logic       push, pop;

  assign cfg_ready_o   = 1'b1;
  assign cfg_req.we    = cfg_valid_i && cfg_ready_o;
  assign cfg_req.index = reg_idx_e'(cfg_index_i);
  assign cfg_req.data  = cfg_data_i;

  bpdd_front #(
    .LANES(LANES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_req),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_action_i   (in_action_i),
    .in_pin_mask_i (in_pin_mask_i),
    .in_now_us_i   (in_now_us_i),
    .in_ack_pin_i  (in_ack_pin_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  bpdd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  bpdd_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_status_i             (q_status),
    .entry_i                (head_entry),
    .pop_o                  (pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_kind_o             (out_kind_o),
    .out_pin_o              (out_pin_o),
    .out_held_us_o          (out_held_us_o),
    .out_rising_edge_mask_o (out_rising_edge_mask_o),
    .out_acked_mask_o       (out_acked_mask_o),
    .out_last_o             (out_last_o)
  );

  // Only the summary closes a request.
  `BPDD_ASSERT_IMPLIES(a_last_iff_summary, out_valid_o, (out_kind_o == KIND_SUMMARY) == out_last_o)
  // A summary carries no pin and no duration.
  `BPDD_ASSERT_IMPLIES(a_summary_clean, out_valid_o && out_kind_o == KIND_SUMMARY, out_pin_o == 4'd0 && out_held_us_o == 32'd0)
  // Release reports name only tracked pins.
  `BPDD_ASSERT_IMPLIES(a_pin_in_range, out_valid_o && out_kind_o == KIND_RELEASE, 32'(out_pin_o) < LANES)
  // Queue occupancy stays consistent.
  `BPDD_ASSERT_NEXT(a_queue_sane, 1'b1, !(q_status.full && q_status.empty))

endmodule

>>> verif/debounce_checker.sv
// Checker for the button debouncer: predicts release reports and summaries and compares them.
module debounce_checker #(
  parameter int unsigned PINS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        in_action_i,
  input  logic [15:0] in_pin_mask_i,
  input  logic [31:0] in_now_us_i,
  input  logic [3:0]  in_ack_pin_i,

  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        out_kind_o,
  input  logic [3:0]  out_pin_o,
  input  logic [31:0] out_held_us_o,
  input  logic [15:0] out_rising_edge_mask_o,
  input  logic [15:0] out_acked_mask_o,
  input  logic        out_last_o,

  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,

  output int          fail_count_o,
  output int          outstanding_o
);
  import bpdd_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [3:0]  pin;
    logic [31:0] held_us;
    logic [15:0] rising;
    logic [15:0] acked;
    logic        last;
  } report_t;

  report_t     expected_reports[$];
  logic [31:0] stamp_us[PIN_MAX];
  logic [15:0] armed_rising;
  logic [15:0] enabled;
  logic [31:0] debounce_us;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // Register write; a pin that becomes enabled starts over as freshly mapped.
  task automatic apply_register(reg_idx_e idx, logic [31:0] data);
    logic [15:0] fresh;
    case (idx)
      REG_ENABLED_MASK: begin
        fresh = data[15:0] & ~enabled;
        for (int i = 0; i < PIN_MAX; i++) begin
          if (fresh[i]) begin
            stamp_us[i]     = '0;
            armed_rising[i] = 1'b0;
          end
        end
        enabled = data[15:0];
      end
      REG_DEBOUNCE_US: debounce_us = data;
      default: ;
    endcase
  endtask

  // Updates stamps and armed edges for one request and queues its reports.
  task automatic predict_releases(action_e act, logic [15:0] mask, logic [31:0] now,
                                  logic [3:0] ack_pin);
    report_t     batch[$];
    report_t     rep;
    logic [31:0] deadline;
    logic [31:0] held;
    if (act == ACT_ACK) begin
      if (ack_pin < PINS) stamp_us[ack_pin] = '0;
    end else begin
      for (int i = 0; i < PINS; i++) begin
        if (!(mask[i] && enabled[i])) continue;
        deadline = stamp_us[i] + debounce_us;
        if (stamp_us[i] == '0) begin
          stamp_us[i]     = now;
          armed_rising[i] = 1'b1;
        end else if (deadline < now) begin
          held            = now - stamp_us[i];
          stamp_us[i]     = held;
          armed_rising[i] = 1'b0;
          rep = '{kind: KIND_RELEASE, pin: 4'(i), held_us: held, rising: '0,
                  acked: mask, last: 1'b0};
          batch.push_back(rep);
        end else begin
          armed_rising[i] = 1'b1;
        end
      end
    end
    rep = '{kind: KIND_SUMMARY, pin: '0, held_us: '0, rising: '0,
            acked: (act == ACT_EDGE) ? mask : 16'h0, last: 1'b1};
    batch.push_back(rep);
    // armed edges are reported as they stand after the whole request
    foreach (batch[k]) begin
      batch[k].rising = armed_rising;
      expected_reports.push_back(batch[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      expected_reports.delete();
      foreach (stamp_us[i]) stamp_us[i] = '0;
      armed_rising  = '0;
      enabled       = '0;
      debounce_us   = DEBOUNCE_RESET;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_register(reg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && !in_stall_o) begin
        predict_releases(action_e'(in_action_i), in_pin_mask_i, in_now_us_i, in_ack_pin_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, kind %0d pin %0d",
                                    out_kind_o, out_pin_o));
        end else begin
          want = expected_reports.pop_front();
          compare_field("kind", 32'(out_kind_o), 32'(want.kind));
          compare_field("pin", 32'(out_pin_o), 32'(want.pin));
          compare_field("held_us", out_held_us_o, want.held_us);
          compare_field("rising_edge_mask", 32'(out_rising_edge_mask_o), 32'(want.rising));
          compare_field("acked_mask", 32'(out_acked_mask_o), 32'(want.acked));
          compare_field("last", 32'(out_last_o), 32'(want.last));
        end
      end
      outstanding_o <= expected_reports.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the button debouncer: stimulus, flow control and verdict.
module tb_top;
  import bpdd_pkg::*;

  // Watchdog: cycles with no accepted request, result or register write.
  localparam int IDLE_LIMIT  = 3000;
  // Long receiver hold-off: starts after this many results, lasts this long.
  // Placed inside the first random phase so the sender keeps offering.
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed after the last result before a register write or the end.
  localparam int DRAIN_CYCLES = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        in_action_i = ACT_EDGE;
  logic [15:0] in_pin_mask_i = '0;
  logic [31:0] in_now_us_i = '0;
  logic [3:0]  in_ack_pin_i = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [3:0]  out_pin_o;
  logic [31:0] out_held_us_o;
  logic [15:0] out_rising_edge_mask_o;
  logic [15:0] out_acked_mask_o;
  logic        out_last_o;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_ENABLED_MASK;
  logic [31:0] cfg_data_i = '0;

  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;
  int          sent = 0;
  bit          sender_calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  button_press_duration_debounce dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_action_i            (in_action_i),
    .in_pin_mask_i          (in_pin_mask_i),
    .in_now_us_i            (in_now_us_i),
    .in_ack_pin_i           (in_ack_pin_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_kind_o             (out_kind_o),
    .out_pin_o              (out_pin_o),
    .out_held_us_o          (out_held_us_o),
    .out_rising_edge_mask_o (out_rising_edge_mask_o),
    .out_acked_mask_o       (out_acked_mask_o),
    .out_last_o             (out_last_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  debounce_checker checker_i (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_action_i            (in_action_i),
    .in_pin_mask_i          (in_pin_mask_i),
    .in_now_us_i            (in_now_us_i),
    .in_ack_pin_i           (in_ack_pin_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_kind_o             (out_kind_o),
    .out_pin_o              (out_pin_o),
    .out_held_us_o          (out_held_us_o),
    .out_rising_edge_mask_o (out_rising_edge_mask_o),
    .out_acked_mask_o       (out_acked_mask_o),
    .out_last_o             (out_last_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .fail_count_o           (fail_count),
    .outstanding_o          (outstanding)
  );

  // Offers one request after a random gap and holds it until taken.
  // Every 16 requests the sender may switch to a stretch with no gaps.
  // Valid stays high between back-to-back requests.
  task automatic send_request(action_e act, logic [15:0] mask, logic [31:0] now,
                              logic [3:0] ack_pin);
    int gap;
    if (sent % 16 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_action_i   <= act;
    in_pin_mask_i <= mask;
    in_now_us_i   <= now;
    in_ack_pin_i  <= ack_pin;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // Both registers, back to back on the write channel. Only called while
  // nothing is in flight.
  task automatic set_registers(logic [15:0] mask, logic [31:0] debounce);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_ENABLED_MASK;
    cfg_data_i  <= {16'h0, mask};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= REG_DEBOUNCE_US;
    cfg_data_i  <= debounce;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for every expected result, then a few spare cycles.
  // outstanding is registered in the checker, so it lags the expected results.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: single pins (sometimes a few) edged at a
  // running time that moves forward by up to about twice the debounce time
  // (debounce capped at 100000), so presses, bounces and releases all show up.
  // Acks favor the pin just edged so that pins go back to idle and get pressed
  // again. The rest is noise with fully random masks and times.
  task automatic random_requests(int count, logic [31:0] debounce);
    logic [31:0] clock_us;
    logic [31:0] span;
    logic [15:0] mask;
    logic [3:0]  focus;
    int          pick;
    clock_us = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                           : 32'($urandom_range(1, 100000));
    span  = (debounce > 32'd100000) ? 32'd100000 : debounce;
    focus = '0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        focus = 4'($urandom_range(0, 15));
        mask  = 16'h1 << focus;
        if ($urandom_range(0, 2) == 0) mask |= 16'($urandom) & 16'($urandom);
        clock_us += $urandom_range(0, 2 * span + 4);
        send_request(ACT_EDGE, mask, clock_us, 4'($urandom));
      end else if (pick < 85) begin
        send_request(ACT_ACK, 16'($urandom), $urandom,
                     ($urandom_range(0, 1) == 1) ? focus : 4'($urandom));
      end else begin
        send_request(ACT_EDGE, 16'($urandom), $urandom, 4'($urandom));
      end
    end
  endtask

  // Result side: random stalls per result, calm stretches, and one long
  // hold-off so the internal queue fills and the block stalls its input.
  initial begin : result_sink
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Watchdog: the run is stuck if nothing moves while the idle count runs up to IDLE_LIMIT.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all pins enabled, short debounce.
    set_registers(16'hFFFF, 32'd100);
    send_request(ACT_EDGE, 16'h0001, 32'd1000, 4'd3);   // press starts on pin 0
    send_request(ACT_EDGE, 16'h0001, 32'd1050, 4'd0);   // bounce inside debounce
    send_request(ACT_EDGE, 16'h0001, 32'd1101, 4'd0);   // release, held 101
    send_request(ACT_EDGE, 16'h0001, 32'd150, 4'd0);    // judged against held time
    send_request(ACT_EDGE, 16'h0001, 32'd5000, 4'd0);   // released again from held
    send_request(ACT_ACK, 16'hFFFF, 32'hFFFF_FFFF, 4'd0);
    send_request(ACT_EDGE, 16'h0000, 32'd7, 4'd15);     // empty mask: summary only
    send_request(ACT_EDGE, 16'h8000, 32'd0, 4'd0);      // time zero keeps pin idle
    send_request(ACT_ACK, 16'h0000, 32'd0, 4'd15);
    send_request(ACT_EDGE, 16'hFFFF, 32'hFFFF_FFFF, 4'd0); // all pins press at max
    send_request(ACT_EDGE, 16'hFFFF, 32'd5, 4'd0);      // wrapped deadline not met
    send_request(ACT_EDGE, 16'hFFFF, 32'd200, 4'd0);    // sixteen releases + summary
    drain_results();

    // Upper pins disabled, maximum debounce: only lower pins react.
    set_registers(16'h00FF, 32'hFFFF_FFFF);
    send_request(ACT_EDGE, 16'hFFFF, 32'd300, 4'd0);
    send_request(ACT_EDGE, 16'hFF00, 32'd400, 4'd0);    // disabled pins only
    drain_results();

    // Re-enabling the upper pins maps them fresh; zero debounce.
    set_registers(16'hFFFF, 32'd0);
    send_request(ACT_EDGE, 16'hFFFF, 32'd500, 4'd0);
    send_request(ACT_EDGE, 16'hFF00, 32'd500, 4'd0);    // equal time is not a release
    send_request(ACT_EDGE, 16'hFF00, 32'd501, 4'd0);
    send_request(ACT_ACK, 16'h0000, 32'd0, 4'd7);
    send_request(ACT_EDGE, 16'h5555, 32'h8000_0000, 4'd0);
    send_request(ACT_EDGE, 16'hAAAA, 32'h7FFF_FFFF, 4'd0);
    drain_results();

    // Random phases over several register settings.
    set_registers(16'hFFFF, 32'($urandom_range(0, 2000)));
    random_requests(60, checker_i.debounce_us);
    drain_results();
    set_registers(16'($urandom), 32'($urandom_range(0, 2000)));
    random_requests(60, checker_i.debounce_us);
    drain_results();
    set_registers(16'hFFFF, 32'hFFFF_FFFF);
    random_requests(60, 32'hFFFF_FFFF);
    drain_results();
    set_registers(16'h0000, 32'd0);
    random_requests(20, 32'd0);
    drain_results();
    set_registers(16'hFFFF, DEBOUNCE_RESET);
    random_requests(60, DEBOUNCE_RESET);
    drain_results();
    set_registers(16'($urandom), 32'($urandom_range(0, 2000)));
    random_requests(60, checker_i.debounce_us);
    drain_results();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> button_press_duration_debounce.f
+incdir+hw/rtl
hw/rtl/bpdd_pkg.sv
hw/rtl/bpdd_front.sv
hw/rtl/bpdd_queue.sv
hw/rtl/bpdd_back.sv
hw/rtl/button_press_duration_debounce.sv
verif/debounce_checker.sv
verif/tb_top.sv
